// ----- hw/rtl/fset_pkg.sv -----
// fset_pkg: shared widths, operation and status codes, register map
// for the forward-star edge table. No dependencies.
package fset_pkg;

  localparam int OP_W     = 2;
  localparam int ID_W     = 16;
  localparam int COST_W   = 31;
  localparam int STATUS_W = 3;
  localparam int DEG_W    = 11;
  localparam int NC_W     = 9;
  localparam int EC_W     = 11;
  localparam int BASE_W   = 16;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 4;
  localparam int REGIX_W  = 2;

  localparam int MAX_NODES_DEF = 256;
  localparam int MAX_EDGES_DEF = 1024;

  localparam logic [NC_W-1:0]   NODE_COUNT_RST = 9'd256;
  localparam logic [EC_W-1:0]   EDGE_CAP_RST   = 11'd1024;
  localparam logic [BASE_W-1:0] NODE_BASE_RST  = 16'd0;

  // register indexes (byte address / 4)
  localparam logic [REGIX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [REGIX_W-1:0] REG_EDGE_CAP   = 2'd1;
  localparam logic [REGIX_W-1:0] REG_NODE_BASE  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DEGREE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SRC   = 3'd1,
    ST_BAD_DST   = 3'd2,
    ST_BAD_COST  = 3'd3,
    ST_DUP       = 3'd4,
    ST_FULL      = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_t;

endpackage

// ----- hw/rtl/fset_if.sv -----
// fset_if: valid/ready channel interfaces for requests and results.
// Depends on fset_pkg for the field widths.
interface fset_in_if;
  logic                          valid;
  logic                          ready;
  logic [fset_pkg::OP_W-1:0]     op;
  logic [fset_pkg::ID_W-1:0]     from_node;
  logic [fset_pkg::ID_W-1:0]     to_node;
  logic [fset_pkg::COST_W-1:0]   edge_cost;

  modport source (output valid, op, from_node, to_node, edge_cost, input ready);
  modport sink   (input valid, op, from_node, to_node, edge_cost, output ready);
endinterface

interface fset_out_if;
  logic                          valid;
  logic                          ready;
  logic [fset_pkg::STATUS_W-1:0] status;
  logic [fset_pkg::COST_W-1:0]   found_cost;
  logic [fset_pkg::DEG_W-1:0]    out_degree;

  modport source (output valid, status, found_cost, out_degree, input ready);
  modport sink   (input valid, status, found_cost, out_degree, output ready);
endinterface

// ----- hw/rtl/forward_star_edge_table.sv -----
// forward_star_edge_table: CSR adjacency store with a small sequencer over
// a segment-start memory and the destination and cost edge memories.
// Depends on fset_pkg and fset_if.
//
// Usage: requests arrive on in_if (op, from_node, to_node, edge_cost); each
// request gives exactly one result beat on out_if (status, found_cost,
// out_degree). Registers node_count, edge_capacity and node_base are written
// over the APB port (byte address 0, 4, 8); the user must write them only
// while the block is idle, which the block itself leaves unenforced. One
// request is worked on at a time; in_if.ready is high only when idle. The
// time from one accepted request to the next is set by the single-port-read
// memory walks: a bad source or unused op skips them, a degree query or bad
// destination or cost reads only the run bounds, a lookup or duplicate insert
// scans the run to a match or its end, a full insert scans the whole run, and
// an insert also shifts the later edges and bumps the later live nodes' starts.
// After reset a clearing pass zeroes the segment starts, during which no
// request is taken (register writes still are).
// The result sits in an output register; a stalled receiver holds it there
// and the next request is taken, but its result waits for the register.
module forward_star_edge_table #(
  parameter int MAX_NODES = fset_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = fset_pkg::MAX_EDGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  fset_in_if.sink                       in_if,
  fset_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fset_pkg::APB_AW-1:0]   paddr,
  input  logic [fset_pkg::APB_DW-1:0]   pwdata,
  output logic [fset_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int NIW  = $clog2(MAX_NODES);
  localparam int NCW  = $clog2(MAX_NODES + 1);
  localparam int LNW  = (NCW > fset_pkg::NC_W) ? NCW : fset_pkg::NC_W;
  localparam int AW   = $clog2(MAX_EDGES);
  localparam int EW   = $clog2(MAX_EDGES + 1);
  localparam int LEW  = (EW > fset_pkg::EC_W) ? EW : fset_pkg::EC_W;
  localparam int IXW  = NIW + 1;
  localparam int CMPW = fset_pkg::ID_W + 1;

  localparam logic [LNW-1:0] MAXN_L   = LNW'(MAX_NODES);
  localparam logic [LEW-1:0] MAXE_L   = LEW'(MAX_EDGES);
  localparam logic [NIW-1:0] LAST_IDX = NIW'(MAX_NODES - 1);

  typedef enum logic [10:0] {
    S_CLR   = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_CHK   = 11'b000_0000_0100,
    S_LO    = 11'b000_0000_1000,
    S_HI    = 11'b000_0001_0000,
    S_BND   = 11'b000_0010_0000,
    S_SCAN  = 11'b000_0100_0000,
    S_SHIFT = 11'b000_1000_0000,
    S_PLACE = 11'b001_0000_0000,
    S_INC   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  // ---------------- configuration registers ----------------
  logic [fset_pkg::NC_W-1:0]    node_count_r;
  logic [fset_pkg::EC_W-1:0]    edge_cap_r;
  logic [fset_pkg::BASE_W-1:0]  node_base_r;
  logic                         cfg_wr;
  logic [fset_pkg::REGIX_W-1:0] cfg_ix;

  assign pready = 1'b1;
  assign cfg_ix = paddr[fset_pkg::APB_AW-1:2];
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= fset_pkg::NODE_COUNT_RST;
      edge_cap_r   <= fset_pkg::EDGE_CAP_RST;
      node_base_r  <= fset_pkg::NODE_BASE_RST;
    end else if (cfg_wr) begin
      case (cfg_ix)
        fset_pkg::REG_NODE_COUNT: node_count_r <= pwdata[fset_pkg::NC_W-1:0];
        fset_pkg::REG_EDGE_CAP:   edge_cap_r   <= pwdata[fset_pkg::EC_W-1:0];
        fset_pkg::REG_NODE_BASE:  node_base_r  <= pwdata[fset_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_ix)
      fset_pkg::REG_NODE_COUNT: prdata = fset_pkg::APB_DW'(node_count_r);
      fset_pkg::REG_EDGE_CAP:   prdata = fset_pkg::APB_DW'(edge_cap_r);
      fset_pkg::REG_NODE_BASE:  prdata = fset_pkg::APB_DW'(node_base_r);
      default:                  prdata = '0;
    endcase
  end

  logic [LNW-1:0] live_nodes;
  logic [LEW-1:0] live_edges;
  assign live_nodes = (LNW'(node_count_r) < MAXN_L) ? LNW'(node_count_r) : MAXN_L;
  assign live_edges = (LEW'(edge_cap_r) < MAXE_L) ? LEW'(edge_cap_r) : MAXE_L;

  // ---------------- memories ----------------
  logic [EW-1:0]                 seg_mem [MAX_NODES];
  logic [EW-1:0]                 seg_q;
  logic                          seg_we;
  logic [NIW-1:0]                seg_wa, seg_ra;
  logic [EW-1:0]                 seg_wd;

  logic [fset_pkg::ID_W-1:0]     dst_mem [MAX_EDGES];
  logic [fset_pkg::COST_W-1:0]   wt_mem  [MAX_EDGES];
  logic [fset_pkg::ID_W-1:0]     dst_q;
  logic [fset_pkg::COST_W-1:0]   wt_q;
  logic                          edge_we;
  logic [AW-1:0]                 edge_wa, edge_ra;
  logic [fset_pkg::ID_W-1:0]     edge_wd_dst;
  logic [fset_pkg::COST_W-1:0]   edge_wd_wt;

  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_mem[seg_wa] <= seg_wd;
    end
    seg_q <= seg_mem[seg_ra];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      dst_mem[edge_wa] <= edge_wd_dst;
      wt_mem[edge_wa]  <= edge_wd_wt;
    end
    dst_q <= dst_mem[edge_ra];
    wt_q  <= wt_mem[edge_ra];
  end

  // ---------------- sequencer state ----------------
  state_t                      state_r, state_nxt;
  fset_pkg::op_t               op_r, op_nxt;
  logic [fset_pkg::ID_W-1:0]   from_r, from_nxt, to_r, to_nxt;
  logic [fset_pkg::COST_W-1:0] cost_r, cost_nxt;
  logic [NIW-1:0]              si_r, si_nxt;
  logic [EW-1:0]               lo_r, lo_nxt, e_r, e_nxt, p_r, p_nxt;
  logic [EW-1:0]               k_r, k_nxt, sh_r, sh_nxt, eu_r, eu_nxt, deg_r, deg_nxt;
  logic [AW-1:0]               kd_r, kd_nxt, wa_r, wa_nxt;
  logic                        hi_mem_r, hi_mem_nxt, cmpv_r, cmpv_nxt, ge_r, ge_nxt;
  logic                        wv_r, wv_nxt, iv_r, iv_nxt, post_r, post_nxt;
  logic [IXW-1:0]              ik_r, ik_nxt;
  logic [NIW-1:0]              iwa_r, iwa_nxt, clr_r, clr_nxt;
  fset_pkg::status_t           status_r, status_nxt;
  logic [fset_pkg::COST_W-1:0] found_r, found_nxt;

  logic                          ov_r, ov_nxt;
  logic [fset_pkg::STATUS_W-1:0] ost_r, ost_nxt;
  logic [fset_pkg::COST_W-1:0]   ocost_r, ocost_nxt;
  logic [fset_pkg::DEG_W-1:0]    odeg_r, odeg_nxt;

  // id range checks
  logic [fset_pkg::ID_W-1:0] src_diff, dst_diff;
  logic                      src_ok, dst_ok;
  assign src_diff = from_r - node_base_r;
  assign dst_diff = to_r - node_base_r;
  assign src_ok   = (from_r >= node_base_r) && (CMPW'(src_diff) < CMPW'(live_nodes));
  assign dst_ok   = (to_r >= node_base_r) && (CMPW'(dst_diff) < CMPW'(live_nodes));

  logic [IXW-1:0] si_inc;
  logic [EW-1:0]  hi_raw, hi_clamp, sh_dec;
  assign si_inc   = IXW'(si_r) + 1'b1;
  assign hi_raw   = hi_mem_r ? seg_q : eu_r;
  assign hi_clamp = (hi_raw > eu_r) ? eu_r : hi_raw;
  assign sh_dec   = sh_r - 1'b1;

  assign in_if.ready       = (state_r == S_IDLE);
  assign out_if.valid      = ov_r;
  assign out_if.status     = ost_r;
  assign out_if.found_cost = ocost_r;
  assign out_if.out_degree = odeg_r;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    from_nxt   = from_r;
    to_nxt     = to_r;
    cost_nxt   = cost_r;
    si_nxt     = si_r;
    lo_nxt     = lo_r;
    e_nxt      = e_r;
    p_nxt      = p_r;
    k_nxt      = k_r;
    kd_nxt     = kd_r;
    sh_nxt     = sh_r;
    wa_nxt     = wa_r;
    eu_nxt     = eu_r;
    deg_nxt    = deg_r;
    hi_mem_nxt = hi_mem_r;
    cmpv_nxt   = cmpv_r;
    ge_nxt     = ge_r;
    wv_nxt     = wv_r;
    iv_nxt     = iv_r;
    post_nxt   = post_r;
    ik_nxt     = ik_r;
    iwa_nxt    = iwa_r;
    clr_nxt    = clr_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    ov_nxt     = ov_r;
    ost_nxt    = ost_r;
    ocost_nxt  = ocost_r;
    odeg_nxt   = odeg_r;

    seg_we      = 1'b0;
    seg_wa      = clr_r;
    seg_wd      = '0;
    seg_ra      = si_r;
    edge_we     = 1'b0;
    edge_wa     = wa_r;
    edge_wd_dst = dst_q;
    edge_wd_wt  = wt_q;
    edge_ra     = k_r[AW-1:0];

    if (ov_r && out_if.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        seg_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_if.valid) begin
          op_nxt    = fset_pkg::op_t'(in_if.op);
          from_nxt  = in_if.from_node;
          to_nxt    = in_if.to_node;
          cost_nxt  = in_if.edge_cost;
          post_nxt  = 1'b0;
          state_nxt = S_CHK;
        end
      end

      S_CHK: begin
        found_nxt = '0;
        deg_nxt   = '0;
        si_nxt    = src_diff[NIW-1:0];
        if (op_r == fset_pkg::OP_NONE) begin
          status_nxt = fset_pkg::ST_OK;
          state_nxt  = S_DONE;
        end else if (!src_ok) begin
          status_nxt = fset_pkg::ST_BAD_SRC;
          state_nxt  = S_DONE;
        end else begin
          if (op_r == fset_pkg::OP_DEGREE) begin
            status_nxt = fset_pkg::ST_OK;
          end else if (!dst_ok) begin
            status_nxt = fset_pkg::ST_BAD_DST;
          end else if (op_r == fset_pkg::OP_INSERT && cost_r == '0) begin
            status_nxt = fset_pkg::ST_BAD_COST;
          end else begin
            status_nxt = fset_pkg::ST_OK;
          end
          state_nxt = S_LO;
        end
      end

      S_LO: begin
        seg_ra    = si_r;
        state_nxt = S_HI;
      end

      S_HI: begin
        lo_nxt = (seg_q > eu_r) ? eu_r : seg_q;
        // the last live node's run ends at the edge count
        if (CMPW'(si_inc) < CMPW'(live_nodes)) begin
          seg_ra     = si_inc[NIW-1:0];
          hi_mem_nxt = 1'b1;
        end else begin
          hi_mem_nxt = 1'b0;
        end
        state_nxt = S_BND;
      end

      S_BND: begin
        e_nxt    = (hi_clamp < lo_r) ? lo_r : hi_clamp;
        deg_nxt  = ((hi_clamp < lo_r) ? lo_r : hi_clamp) - lo_r;
        k_nxt    = lo_r;
        p_nxt    = (hi_clamp < lo_r) ? lo_r : hi_clamp;
        ge_nxt   = 1'b0;
        cmpv_nxt = 1'b0;
        if (post_r || op_r == fset_pkg::OP_DEGREE || status_r != fset_pkg::ST_OK) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // one slot read per cycle; the compare works on each read in the cycle after it
        if (k_r < e_r) begin
          edge_ra  = k_r[AW-1:0];
          kd_nxt   = k_r[AW-1:0];
          cmpv_nxt = 1'b1;
          k_nxt    = k_r + 1'b1;
        end else begin
          cmpv_nxt = 1'b0;
        end
        if (cmpv_r && dst_q == to_r) begin
          if (op_r == fset_pkg::OP_LOOKUP) begin
            found_nxt = wt_q;
          end else begin
            status_nxt = fset_pkg::ST_DUP;
          end
          state_nxt = S_DONE;
        end else if (cmpv_r && !ge_r && dst_q > to_r) begin
          ge_nxt = 1'b1;
          p_nxt  = EW'(kd_r);
        end else if (!cmpv_r && k_r >= e_r) begin
          if (op_r == fset_pkg::OP_LOOKUP) begin
            status_nxt = fset_pkg::ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end else if (LEW'(eu_r) >= live_edges) begin
            status_nxt = fset_pkg::ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            sh_nxt    = eu_r;
            wv_nxt    = 1'b0;
            state_nxt = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // read slot sh-1 now, write it to slot sh on the next cycle
        if (wv_r) begin
          edge_we = 1'b1;
          edge_wa = wa_r;
        end
        if (sh_r > p_r) begin
          edge_ra = sh_dec[AW-1:0];
          wa_nxt  = sh_r[AW-1:0];
          wv_nxt  = 1'b1;
          sh_nxt  = sh_dec;
        end else begin
          wv_nxt = 1'b0;
          if (!wv_r) begin
            state_nxt = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        edge_we     = 1'b1;
        edge_wa     = p_r[AW-1:0];
        edge_wd_dst = to_r;
        edge_wd_wt  = cost_r;
        eu_nxt      = eu_r + 1'b1;
        ik_nxt      = si_inc;
        iv_nxt      = 1'b0;
        state_nxt   = S_INC;
      end

      S_INC: begin
        // read-modify-write of later segment starts, one per cycle
        if (iv_r) begin
          seg_we = 1'b1;
          seg_wa = iwa_r;
          seg_wd = seg_q + 1'b1;
        end
        if (CMPW'(ik_r) < CMPW'(live_nodes)) begin
          seg_ra  = ik_r[NIW-1:0];
          iwa_nxt = ik_r[NIW-1:0];
          iv_nxt  = 1'b1;
          ik_nxt  = ik_r + 1'b1;
        end else begin
          iv_nxt = 1'b0;
          if (!iv_r) begin
            post_nxt  = 1'b1;
            state_nxt = S_LO;
          end
        end
      end

      S_DONE: begin
        if (!ov_r || out_if.ready) begin
          ov_nxt    = 1'b1;
          ost_nxt   = status_r;
          ocost_nxt = found_r;
          odeg_nxt  = fset_pkg::DEG_W'(deg_r);
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      eu_r    <= '0;
      ov_r    <= 1'b0;
      cmpv_r  <= 1'b0;
      wv_r    <= 1'b0;
      iv_r    <= 1'b0;
      post_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      eu_r    <= eu_nxt;
      ov_r    <= ov_nxt;
      cmpv_r  <= cmpv_nxt;
      wv_r    <= wv_nxt;
      iv_r    <= iv_nxt;
      post_r  <= post_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    from_r   <= from_nxt;
    to_r     <= to_nxt;
    cost_r   <= cost_nxt;
    si_r     <= si_nxt;
    lo_r     <= lo_nxt;
    e_r      <= e_nxt;
    p_r      <= p_nxt;
    k_r      <= k_nxt;
    kd_r     <= kd_nxt;
    sh_r     <= sh_nxt;
    wa_r     <= wa_nxt;
    deg_r    <= deg_nxt;
    hi_mem_r <= hi_mem_nxt;
    ge_r     <= ge_nxt;
    ik_r     <= ik_nxt;
    iwa_r    <= iwa_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    ost_r    <= ost_nxt;
    ocost_r  <= ocost_nxt;
    odeg_r   <= odeg_nxt;
  end

endmodule

// ----- hw/rtl/fset_checker.sv -----
// fset_checker: port-level assertions for forward_star_edge_table, and the
// bind that attaches them. Depends on fset_pkg.
module fset_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fset_pkg::STATUS_W-1:0] out_status,
  input logic [fset_pkg::COST_W-1:0]   out_found_cost,
  input logic [fset_pkg::DEG_W-1:0]    out_out_degree
);

  // one request at a time: an accepted beat makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one still in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= fset_pkg::ST_NOT_FOUND)
    else $error("status code out of range");

  a_cost_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != fset_pkg::ST_OK |-> out_found_cost == '0)
    else $error("cost reported on a failed operation");

  a_bad_src_no_degree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == fset_pkg::ST_BAD_SRC |-> out_out_degree == '0)
    else $error("degree reported for a bad source");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result beat dropped or changed under stall");

endmodule

bind forward_star_edge_table fset_checker u_fset_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_status     (out_if.status),
  .out_found_cost (out_if.found_cost),
  .out_out_degree (out_if.out_degree)
);

// ----- tb/tb_forward_star_edge_table.sv -----
// Self-checking testbench for forward_star_edge_table: drives all four request
// ops and register writes, predicts every result beat in-line.
// Depends on fset_pkg, fset_if and the forward_star_edge_table RTL.
module tb_forward_star_edge_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_SLOTS = fset_pkg::MAX_NODES_DEF;
  localparam int EDGE_SLOTS = fset_pkg::MAX_EDGES_DEF;
  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam int SHOWN_ERRORS = 10;

  typedef struct {
    fset_pkg::status_t           status;
    logic [fset_pkg::COST_W-1:0] cost;
    logic [fset_pkg::DEG_W-1:0]  degree;
  } edge_reply_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        psel, penable, pwrite, pready;
  logic [fset_pkg::APB_AW-1:0] paddr;
  logic [fset_pkg::APB_DW-1:0] pwdata, prdata;

  fset_in_if  in_if();
  fset_out_if out_if();

  forward_star_edge_table dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // predicted table contents and register copies
  logic [fset_pkg::DEG_W-1:0]  seg_first [NODE_SLOTS];
  logic [fset_pkg::ID_W-1:0]   dest_mem  [EDGE_SLOTS];
  logic [fset_pkg::COST_W-1:0] cost_mem  [EDGE_SLOTS];
  int unsigned                 n_edges;
  logic [fset_pkg::NC_W-1:0]   cfg_nodes;
  logic [fset_pkg::EC_W-1:0]   cfg_cap;
  logic [fset_pkg::BASE_W-1:0] cfg_base;
  edge_reply_t                 replies_due[$];

  int          error_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  longint      cycle_count = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int          hold_left = 0;
  int          rdy_run = 0;
  bit          rdy_level = 1'b1;

  function automatic int unsigned live_nodes();
    return (cfg_nodes < NODE_SLOTS) ? 32'(cfg_nodes) : NODE_SLOTS;
  endfunction

  function automatic int unsigned live_slots();
    return (cfg_cap < EDGE_SLOTS) ? 32'(cfg_cap) : EDGE_SLOTS;
  endfunction

  function automatic bit node_of(input logic [fset_pkg::ID_W-1:0] id,
                                 output int unsigned idx);
    idx = 32'(id) - 32'(cfg_base);
    return (id >= cfg_base) && (idx < live_nodes());
  endfunction

  // a run whose end lies below its start counts as empty
  function automatic void run_span(input int unsigned i, output int unsigned lo, hi);
    lo = 32'(seg_first[i]);
    hi = (i + 1 < live_nodes()) ? 32'(seg_first[i + 1]) : n_edges;
    if (lo > n_edges) lo = n_edges;
    if (hi > n_edges) hi = n_edges;
    if (hi < lo) hi = lo;
  endfunction

  function automatic void store_edge(int unsigned si, logic [fset_pkg::ID_W-1:0] dst,
                                     logic [fset_pkg::COST_W-1:0] cost,
                                     int unsigned lo, hi);
    int unsigned p, k;
    p = lo;
    while (p < hi && dest_mem[p] < dst) p++;
    for (k = n_edges; k > p; k--) begin
      dest_mem[k] = dest_mem[k - 1];
      cost_mem[k] = cost_mem[k - 1];
    end
    dest_mem[p] = dst;
    cost_mem[p] = cost;
    n_edges++;
    for (k = si + 1; k < live_nodes(); k++) seg_first[k]++;
  endfunction

  function automatic edge_reply_t predict_reply(fset_pkg::op_t op,
                                                logic [fset_pkg::ID_W-1:0] src, dst,
                                                logic [fset_pkg::COST_W-1:0] cost);
    edge_reply_t r;
    int unsigned si, di, lo, hi, p, k;
    bit hit;
    r.status = fset_pkg::ST_OK;
    r.cost   = '0;
    r.degree = '0;
    if (op == fset_pkg::OP_NONE) return r;
    if (!node_of(src, si)) begin
      r.status = fset_pkg::ST_BAD_SRC;
      return r;
    end
    if (op != fset_pkg::OP_DEGREE) begin
      run_span(si, lo, hi);
      hit = 1'b0;
      p = lo;
      for (k = lo; k < hi; k++) begin
        if (dest_mem[k] == dst) begin
          hit = 1'b1;
          p = k;
          break;
        end
      end
      if (!node_of(dst, di)) r.status = fset_pkg::ST_BAD_DST;
      else if (op == fset_pkg::OP_LOOKUP) begin
        if (hit) r.cost = cost_mem[p];
        else r.status = fset_pkg::ST_NOT_FOUND;
      end else if (cost == '0) r.status = fset_pkg::ST_BAD_COST;
      else if (hit) r.status = fset_pkg::ST_DUP;
      else if (n_edges >= live_slots()) r.status = fset_pkg::ST_FULL;
      else store_edge(si, dst, cost, lo, hi);
    end
    run_span(si, lo, hi);
    r.degree = fset_pkg::DEG_W'(hi - lo);
    return r;
  endfunction

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= SHOWN_ERRORS) $display("[%0t] ERROR %s", $realtime, msg);
  endfunction

  // ---------------- channel drivers ----------------

  task automatic send_request(fset_pkg::op_t op, logic [fset_pkg::ID_W-1:0] src, dst,
                              logic [fset_pkg::COST_W-1:0] cost);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_if.valid     <= 1'b1;
    in_if.op        <= op;
    in_if.from_node <= src;
    in_if.to_node   <= dst;
    in_if.edge_cost <= cost;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    replies_due.push_back(predict_reply(op, src, dst, cost));
    sent_count++;
  endtask

  // sender idles until every expected beat is back
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // APB write, then read back the same register
  task automatic write_register(logic [fset_pkg::REGIX_W-1:0] idx,
                                logic [fset_pkg::APB_DW-1:0] value);
    logic [fset_pkg::APB_DW-1:0] shown;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      fset_pkg::REG_NODE_COUNT: begin
        cfg_nodes = value[fset_pkg::NC_W-1:0];
        shown = fset_pkg::APB_DW'(cfg_nodes);
      end
      fset_pkg::REG_EDGE_CAP: begin
        cfg_cap = value[fset_pkg::EC_W-1:0];
        shown = fset_pkg::APB_DW'(cfg_cap);
      end
      default: begin
        cfg_base = value[fset_pkg::BASE_W-1:0];
        shown = fset_pkg::APB_DW'(cfg_base);
      end
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== shown)
      flag_error($sformatf("register %0d readback exp %0h got %0h", idx, shown, prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_registers(logic [fset_pkg::NC_W-1:0] nodes,
                               logic [fset_pkg::EC_W-1:0] cap,
                               logic [fset_pkg::BASE_W-1:0] base);
    drain();
    // junk in the unused upper bits must not stick
    write_register(fset_pkg::REG_NODE_COUNT,
                   {$urandom_range(0, 1) ? 23'h7fffff : 23'h0, nodes});
    write_register(fset_pkg::REG_EDGE_CAP,
                   {$urandom_range(0, 1) ? 21'h1fffff : 21'h0, cap});
    write_register(fset_pkg::REG_NODE_BASE, {16'($urandom()), base});
  endtask

  // ---------------- random request shaping ----------------

  function automatic logic [fset_pkg::ID_W-1:0] pick_id();
    int unsigned roll, ln;
    roll = $urandom_range(0, 99);
    ln = live_nodes();
    if (roll < 85 && ln != 0)
      return fset_pkg::ID_W'(32'(cfg_base) + $urandom_range(0, ln - 1));
    if (roll < 92)
      return $urandom_range(0, 1) ? cfg_base - 16'd1 : cfg_base + fset_pkg::ID_W'(ln);
    return fset_pkg::ID_W'($urandom());
  endfunction

  function automatic logic [fset_pkg::COST_W-1:0] pick_cost();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return '0;
    if (roll < 12) return '1;
    if (roll < 18) return fset_pkg::COST_W'(1);
    return fset_pkg::COST_W'($urandom());
  endfunction

  task automatic send_random();
    int unsigned roll, si, lo, hi;
    fset_pkg::op_t op;
    logic [fset_pkg::ID_W-1:0] src, dst;
    roll = $urandom_range(0, 99);
    op = (roll < 45) ? fset_pkg::OP_INSERT : (roll < 75) ? fset_pkg::OP_LOOKUP :
         (roll < 93) ? fset_pkg::OP_DEGREE : fset_pkg::OP_NONE;
    src = pick_id();
    dst = pick_id();
    // half the time aim at an edge already in the source's run
    if (node_of(src, si) && $urandom_range(0, 1)) begin
      run_span(si, lo, hi);
      if (hi > lo) dst = dest_mem[$urandom_range(lo, hi - 1)];
    end
    if (op == fset_pkg::OP_DEGREE || op == fset_pkg::OP_NONE)
      dst = fset_pkg::ID_W'($urandom());
    send_request(op, src, dst, pick_cost());
  endtask

  task automatic run_phase(logic [fset_pkg::NC_W-1:0] nodes,
                           logic [fset_pkg::EC_W-1:0] cap,
                           logic [fset_pkg::BASE_W-1:0] base, int unsigned items);
    set_registers(nodes, cap, base);
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 64 == 0) begin
        gaps_on   = $urandom_range(0, 2) != 0;
        stalls_on = $urandom_range(0, 2) != 0;
      end
      send_random();
    end
  endtask

  // ---------------- tests ----------------

  task automatic test_directed();
    set_registers(9'd256, 11'd1024, 16'd0);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_request(fset_pkg::OP_DEGREE, 16'd0, 16'd0, 31'd0);
    send_request(fset_pkg::OP_LOOKUP, 16'd0, 16'd0, 31'd0);
    send_request(fset_pkg::OP_INSERT, 16'd0, 16'd5, 31'd0);
    send_request(fset_pkg::OP_INSERT, 16'd0, 16'd5, '1);
    send_request(fset_pkg::OP_INSERT, 16'd0, 16'd5, 31'd1);
    send_request(fset_pkg::OP_INSERT, 16'd0, 16'd2, 31'd1);
    send_request(fset_pkg::OP_INSERT, 16'd0, 16'd255, 31'd12345);
    send_request(fset_pkg::OP_INSERT, 16'd255, 16'd0, 31'd3);
    send_request(fset_pkg::OP_INSERT, 16'd256, 16'd0, 31'd5);
    send_request(fset_pkg::OP_INSERT, 16'hffff, 16'hffff, '1);
    send_request(fset_pkg::OP_INSERT, 16'd3, 16'hffff, 31'd5);
    send_request(fset_pkg::OP_INSERT, 16'd3, 16'd256, 31'd5);
    send_request(fset_pkg::OP_INSERT, 16'd3, 16'd0, 31'd0);
    send_request(fset_pkg::OP_LOOKUP, 16'd0, 16'd5, 31'd0);
    send_request(fset_pkg::OP_LOOKUP, 16'd0, 16'd2, '1);
    send_request(fset_pkg::OP_LOOKUP, 16'd255, 16'd0, 31'd0);
    send_request(fset_pkg::OP_LOOKUP, 16'd0, 16'd9, 31'd0);
    send_request(fset_pkg::OP_LOOKUP, 16'd0, 16'hffff, 31'd0);
    send_request(fset_pkg::OP_LOOKUP, 16'hffff, 16'd0, 31'd0);
    send_request(fset_pkg::OP_DEGREE, 16'd255, 16'hffff, '1);
    send_request(fset_pkg::OP_DEGREE, 16'hffff, 16'd0, 31'd0);
    send_request(fset_pkg::OP_NONE, 16'hffff, 16'hffff, '1);
    // middle node: shifts the last node's edge one slot right
    send_request(fset_pkg::OP_INSERT, 16'd1, 16'd0, 31'd99);
    send_request(fset_pkg::OP_DEGREE, 16'd0, 16'd0, 31'd0);
    send_request(fset_pkg::OP_LOOKUP, 16'd255, 16'd0, 31'd0);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_small_graph();
    run_phase(9'd8, fset_pkg::EC_W'(n_edges + 40), 16'd0, 150);
  endtask

  task automatic test_high_base();
    run_phase(9'd256, fset_pkg::EC_W'(n_edges + 150), 16'hff00, 200);
  endtask

  // long output stall: result register fills, input must back up
  task automatic test_backpressure();
    drain();
    gaps_on = 1'b0;
    hold_left = 400;
    repeat (16) send_random();
    drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_single_node();
    run_phase(9'd1, fset_pkg::EC_W'(n_edges + 30), 16'hffff, 80);
  endtask

  task automatic test_no_nodes();
    run_phase(9'd0, 11'd1024, 16'd0, 40);
  endtask

  task automatic test_no_capacity();
    run_phase(9'd200, 11'd0, 16'h0100, 60);
  endtask

  task automatic test_wide_registers();
    run_phase(9'h1ff, 11'h7ff, 16'd0, 250);
  endtask

  // capacity below occupancy: every insert that is neither rejected nor a duplicate is full
  task automatic test_full_table();
    run_phase(9'd2, 11'd1, 16'h8000, 60);
  endtask

  task automatic test_long_run();
    run_phase(9'd256, fset_pkg::EC_W'(n_edges + 200), 16'd0, 470);
  endtask

  // ---------------- result checking ----------------

  always @(posedge clk) begin
    edge_reply_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      checked_count++;
      if (replies_due.size() == 0) begin
        flag_error($sformatf("result beat with nothing pending: status %0d cost %0h deg %0d",
                             out_if.status, out_if.found_cost, out_if.out_degree));
      end else begin
        want = replies_due.pop_front();
        if (out_if.status !== want.status || out_if.found_cost !== want.cost ||
            out_if.out_degree !== want.degree)
          flag_error($sformatf(
            "beat %0d: exp %s cost %0h deg %0d, got status %0d cost %0h deg %0d",
            checked_count, want.status.name(), want.cost, want.degree,
            out_if.status, out_if.found_cost, out_if.out_degree));
      end
    end
  end

  // receiver: random ready pattern, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      if (rdy_run == 0) begin
        rdy_level = !rdy_level || !stalls_on;
        rdy_run = rdy_level ? $urandom_range(1, 16) : $urandom_range(1, 5);
      end
      rdy_run--;
      out_if.ready <= rdy_level;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still pending",
               cycle_count, replies_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.op        = fset_pkg::OP_NONE;
    in_if.from_node = '0;
    in_if.to_node   = '0;
    in_if.edge_cost = '0;
    out_if.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    foreach (seg_first[i]) seg_first[i] = '0;
    n_edges   = 0;
    cfg_nodes = fset_pkg::NODE_COUNT_RST;
    cfg_cap   = fset_pkg::EDGE_CAP_RST;
    cfg_base  = fset_pkg::NODE_BASE_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_small_graph();
    test_high_base();
    test_backpressure();
    test_single_node();
    test_no_nodes();
    test_no_capacity();
    test_wide_registers();
    test_full_table();
    test_long_run();

    drain();
    repeat (50) @(posedge clk);
    $display("Covered %0d requests, %0d result beats compared, %0d edges stored at end.",
             sent_count, checked_count, n_edges);
    $display("Registers swept across node_count 0..511, edge_capacity 0..2047, %s",
             "node_base 0..65535, with a 400-cycle output stall.");
    if (error_count == 0 && replies_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/fset_pkg.sv
hw/rtl/fset_if.sv
hw/rtl/forward_star_edge_table.sv
hw/rtl/fset_checker.sv
tb/tb_forward_star_edge_table.sv
